[src/scrm_pkg.sv]
// scrm_pkg: shared types, field widths, opcodes and status codes for the
// source channel router and mixer. No dependencies.

package scrm_pkg;

    localparam int DEF_TABLE_ENTRIES      = 64;
    localparam int DEF_NUM_CHANNELS       = 16;
    localparam int DEF_FRAMES_PER_CHANNEL = 1024;
    localparam int DEF_SAMPLE_BITS        = 24;

    localparam int FUNC_W   = 2;
    localparam int SRC_W    = 31;
    localparam int CHSEL_W  = 8;
    localparam int FIDX_W   = 10;
    localparam int SAMP_W   = 24;
    localparam int STATUS_W = 2;
    localparam int MIX_W    = 28;

    localparam int MIX_MAX = 134217727;
    localparam int MIX_MIN = -134217728;

    typedef logic [FUNC_W-1:0]   func_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam func_t FN_MAP   = 2'd0;
    localparam func_t FN_UNMAP = 2'd1;
    localparam func_t FN_ROUTE = 2'd2;
    localparam func_t FN_MIX   = 2'd3;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_NOMAP = 2'd2;
    localparam status_t ST_RANGE = 2'd3;

endpackage

[src/scrm_ram.sv]
// scrm_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.

module scrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[src/source_channel_router_mixer_core.sv]
// source_channel_router_mixer_core: source-to-channel map table, per-channel
// frame stores and mixer under one sequencer.
// Depends on scrm_pkg and scrm_ram.
//
// After reset the block sweeps the channel store to zero, one word a cycle,
// NUM_CHANNELS * 2^ceil(log2(FRAMES_PER_CHANNEL)) words (16384 by default),
// with busy high. A command is taken when start is high and busy is low.
// Map, unmap and route scan the table one entry a cycle through the table
// RAM's single read port: a hit ends the scan at the matching entry, a miss
// reads every filled entry (none on an empty table). A mix reads the
// stores one channel a cycle, all NUM_CHANNELS of them; a mix with an
// out-of-range frame index answers from idle with ST_RANGE and reads none.
// The result shows on status and mixed_sample for one cycle with done high,
// in the cycle after the work ends; it cannot be held off, and a new start
// is taken in that cycle.

module source_channel_router_mixer_core
    import scrm_pkg::*;
#(
    parameter int TABLE_ENTRIES      = DEF_TABLE_ENTRIES,
    parameter int NUM_CHANNELS       = DEF_NUM_CHANNELS,
    parameter int FRAMES_PER_CHANNEL = DEF_FRAMES_PER_CHANNEL,
    parameter int SAMPLE_BITS        = DEF_SAMPLE_BITS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [FUNC_W-1:0]          func,
    input  logic [SRC_W-1:0]           source_id,
    input  logic [CHSEL_W-1:0]         channel_sel,
    input  logic [FIDX_W-1:0]          frame_index,
    input  logic signed [SAMP_W-1:0]   sample_in,
    output logic                       busy,
    output logic                       done,
    output logic [STATUS_W-1:0]        status,
    output logic signed [MIX_W-1:0]    mixed_sample
);

    localparam int TE_AW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W    = $clog2(TABLE_ENTRIES + 1);
    localparam int CH_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CHC_W    = $clog2(NUM_CHANNELS + 1);
    localparam int FR_W     = $clog2(FRAMES_PER_CHANNEL);
    localparam int FX_W     = (FR_W > FIDX_W) ? FR_W : FIDX_W;
    localparam int ST_DEPTH = NUM_CHANNELS << FR_W;
    localparam int ST_AW    = $clog2(ST_DEPTH);
    localparam int ENT_W    = 1 + CHSEL_W + SRC_W;
    localparam int ACC_W    = SAMPLE_BITS + CHC_W;
    localparam int SAT_W    = (ACC_W > MIX_W) ? ACC_W : MIX_W;

    localparam logic [CHSEL_W-1:0]     NUM_CH_C  = CHSEL_W'(NUM_CHANNELS);
    localparam logic [CHC_W-1:0]       NUM_CH_CC = CHC_W'(NUM_CHANNELS);
    localparam logic [CNT_W-1:0]       TE_C      = CNT_W'(TABLE_ENTRIES);
    localparam logic [ST_AW-1:0]       CLR_LAST  = ST_AW'(ST_DEPTH - 1);
    localparam logic signed [SAT_W-1:0] SAT_HI   = SAT_W'(MIX_MAX);
    localparam logic signed [SAT_W-1:0] SAT_LO   = SAT_W'(MIX_MIN);

    localparam logic [1:0] S_CLEAR  = 2'd0;
    localparam logic [1:0] S_IDLE   = 2'd1;
    localparam logic [1:0] S_SEARCH = 2'd2;
    localparam logic [1:0] S_MIX    = 2'd3;

    logic [1:0]                    state_reg, state_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [CNT_W-1:0]              idx_reg, idx_next;
    logic                          chk_reg, chk_next;
    logic [CNT_W-1:0]              chk_idx_reg, chk_idx_next;
    logic [CHC_W-1:0]              ch_reg, ch_next;
    logic [ST_AW-1:0]              clr_reg, clr_next;
    logic                          done_reg, done_next;

    func_t                         func_reg, func_next;
    logic [SRC_W-1:0]              id_reg, id_next;
    logic [CHSEL_W-1:0]            chsel_reg, chsel_next;
    logic [FX_W-1:0]               fidx_reg, fidx_next;
    logic signed [SAMPLE_BITS-1:0] samp_reg, samp_next;
    logic signed [ACC_W-1:0]       acc_reg, acc_next;
    status_t                       status_reg, status_next;
    logic signed [MIX_W-1:0]       mix_reg, mix_next;

    logic                    ent_we;
    logic [TE_AW-1:0]        ent_wa;
    logic [ENT_W-1:0]        ent_wd;
    logic [TE_AW-1:0]        ent_ra;
    logic [ENT_W-1:0]        ent_rd;
    logic                    st_we;
    logic [ST_AW-1:0]        st_wa;
    logic [SAMPLE_BITS-1:0]  st_wd;
    logic [ST_AW-1:0]        st_ra;
    logic [SAMPLE_BITS-1:0]  st_rd;

    logic [SRC_W-1:0]        ent_src;
    logic [CHSEL_W-1:0]      ent_ch;
    logic                    ent_act;
    logic                    hit;
    logic                    scan_end;
    logic                    frame_ok;
    logic signed [SAT_W-1:0] acc_sat;
    logic signed [MIX_W-1:0] mix_sat;

    scrm_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_wa),
        .wdata (ent_wd),
        .raddr (ent_ra),
        .rdata (ent_rd)
    );

    scrm_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (ST_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_wa),
        .wdata (st_wd),
        .raddr (st_ra),
        .rdata (st_rd)
    );

    assign ent_src  = ent_rd[SRC_W-1:0];
    assign ent_ch   = ent_rd[SRC_W +: CHSEL_W];
    assign ent_act  = ent_rd[ENT_W-1];
    assign hit      = chk_reg && (ent_src == id_reg) && (ent_act || (func_reg != FN_ROUTE));
    assign scan_end = !chk_reg && (idx_reg >= cnt_reg);
    assign frame_ok = 32'(fidx_reg) < 32'(FRAMES_PER_CHANNEL);

    always_comb
    begin
        acc_sat = SAT_W'(acc_reg);
        if (acc_sat > SAT_HI)
        begin
            mix_sat = MIX_W'(SAT_HI);
        end
        else if (acc_sat < SAT_LO)
        begin
            mix_sat = MIX_W'(SAT_LO);
        end
        else
        begin
            mix_sat = MIX_W'(acc_sat);
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        chk_next     = chk_reg;
        chk_idx_next = chk_idx_reg;
        ch_next      = ch_reg;
        clr_next     = clr_reg;
        done_next    = 1'b0;
        func_next    = func_reg;
        id_next      = id_reg;
        chsel_next   = chsel_reg;
        fidx_next    = fidx_reg;
        samp_next    = samp_reg;
        acc_next     = acc_reg;
        status_next  = status_reg;
        mix_next     = mix_reg;

        ent_we = 1'b0;
        ent_wa = chk_idx_reg[TE_AW-1:0];
        ent_wd = {1'b1, chsel_reg, id_reg};
        ent_ra = idx_reg[TE_AW-1:0];
        st_we  = 1'b0;
        st_wa  = ST_AW'({ent_ch[CH_W-1:0], fidx_reg[FR_W-1:0]});
        st_wd  = samp_reg;
        st_ra  = ST_AW'({ch_reg[CH_W-1:0], fidx_reg[FR_W-1:0]});

        case (state_reg)
            S_CLEAR:
            begin
                st_we    = 1'b1;
                st_wa    = clr_reg;
                st_wd    = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CLR_LAST)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    func_next  = func;
                    id_next    = source_id;
                    chsel_next = channel_sel;
                    fidx_next  = FX_W'(frame_index);
                    samp_next  = SAMPLE_BITS'(sample_in);
                    idx_next   = '0;
                    chk_next   = 1'b0;
                    ch_next    = '0;
                    acc_next   = '0;
                    if (func != FN_MIX)
                    begin
                        state_next = S_SEARCH;
                    end
                    else if (32'(frame_index) < 32'(FRAMES_PER_CHANNEL))
                    begin
                        state_next = S_MIX;
                    end
                    else
                    begin
                        done_next   = 1'b1;
                        status_next = ST_RANGE;
                        mix_next    = '0;
                    end
                end
            end

            S_SEARCH:
            begin
                if (idx_reg < cnt_reg)
                begin
                    idx_next     = idx_reg + 1'b1;
                    chk_next     = 1'b1;
                    chk_idx_next = idx_reg;
                end
                else
                begin
                    chk_next = 1'b0;
                end

                if (hit)
                begin
                    state_next  = S_IDLE;
                    done_next   = 1'b1;
                    mix_next    = '0;
                    status_next = ST_OK;
                    case (func_reg)
                        FN_MAP:
                        begin
                            ent_we = 1'b1;
                        end
                        FN_UNMAP:
                        begin
                            ent_we = 1'b1;
                            ent_wd = {1'b0, ent_ch, ent_src};
                        end
                        FN_ROUTE:
                        begin
                            if ((ent_ch < NUM_CH_C) && frame_ok)
                            begin
                                st_we = 1'b1;
                            end
                            else
                            begin
                                status_next = ST_RANGE;
                            end
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
                else if (scan_end)
                begin
                    state_next  = S_IDLE;
                    done_next   = 1'b1;
                    mix_next    = '0;
                    status_next = ST_NOMAP;
                    if (func_reg == FN_MAP)
                    begin
                        if (cnt_reg < TE_C)
                        begin
                            ent_we      = 1'b1;
                            ent_wa      = cnt_reg[TE_AW-1:0];
                            cnt_next    = cnt_reg + 1'b1;
                            status_next = ST_OK;
                        end
                        else
                        begin
                            status_next = ST_FULL;
                        end
                    end
                end
            end

            S_MIX:
            begin
                if (ch_reg < NUM_CH_CC)
                begin
                    ch_next  = ch_reg + 1'b1;
                    chk_next = 1'b1;
                end
                else
                begin
                    chk_next = 1'b0;
                end
                if (chk_reg)
                begin
                    acc_next = acc_reg + ACC_W'($signed(st_rd));
                end
                if ((ch_reg == NUM_CH_CC) && !chk_reg)
                begin
                    state_next  = S_IDLE;
                    done_next   = 1'b1;
                    status_next = ST_OK;
                    mix_next    = mix_sat;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            cnt_reg     <= '0;
            idx_reg     <= '0;
            chk_reg     <= 1'b0;
            chk_idx_reg <= '0;
            ch_reg      <= '0;
            clr_reg     <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            idx_reg     <= idx_next;
            chk_reg     <= chk_next;
            chk_idx_reg <= chk_idx_next;
            ch_reg      <= ch_next;
            clr_reg     <= clr_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        id_reg     <= id_next;
        chsel_reg  <= chsel_next;
        fidx_reg   <= fidx_next;
        samp_reg   <= samp_next;
        acc_reg    <= acc_next;
        status_reg <= status_next;
        mix_reg    <= mix_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign status       = status_reg;
    assign mixed_sample = mix_reg;

`ifndef ASSERT_OFF
    a_done_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !done_reg)
        else $error("result strobe while sequencer busy");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= TE_C)
        else $error("table fill count beyond table size");

    a_mix_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (mix_reg != '0)) |-> (status_reg == ST_OK))
        else $error("nonzero mix with error status");

    a_mix_chan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MIX) |-> (ch_reg <= NUM_CH_CC))
        else $error("mix channel counter out of range");

    a_count_grows_by_map: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != $past(cnt_reg)) |-> ($past(func_reg) == FN_MAP))
        else $error("table grew outside a map transfer");
`endif

endmodule
